// ===== rtl/core/mps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types, codes and defaults of the multilevel priority fifo scheduler.
// ----------------------------------------------------------------------------
package mps_pkg;

  localparam int DEF_PRIORITY_LEVELS = 8;
  localparam int DEF_MAX_THREADS     = 64;

  // fixed field widths of the item payloads
  localparam int OPCODE_W = 2;
  localparam int TID_FW   = 6;
  localparam int PRI_FW   = 3;
  localparam int IST_FW   = 2;
  localparam int SLICE_W  = 20;
  localparam int SBASE_W  = 16;

  localparam logic [SLICE_W-1:0] SLICE_MAX      = 20'hFFFFF;
  localparam logic [SBASE_W-1:0] SLICE_BASE_RST = 16'd10;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [0:0] REG_SLICE_BASE = 1'b0;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_YIELD = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TERM  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_START = 2'd3;

  // initial state codes given with add
  localparam logic [IST_FW-1:0] IST_READY   = 2'd0;
  localparam logic [IST_FW-1:0] IST_SLEEP   = 2'd1;
  localparam logic [IST_FW-1:0] IST_CREATED = 2'd2;
  localparam logic [IST_FW-1:0] IST_BAD     = 2'd3;

  // thread states held in the thread memory
  localparam int TS_W = 3;
  typedef logic [TS_W-1:0] tstate_t;
  localparam tstate_t TS_UNUSED  = 3'd0;
  localparam tstate_t TS_READY   = 3'd1;
  localparam tstate_t TS_SLEEP   = 3'd2;
  localparam tstate_t TS_CREATED = 3'd3;
  localparam tstate_t TS_RUNNING = 3'd4;
  localparam tstate_t TS_EXITED  = 3'd5;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [TID_FW-1:0]   thread_id;
    logic [PRI_FW-1:0]   priority_level;
    logic [IST_FW-1:0]   initial_state;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic               dispatched;
    logic [TID_FW-1:0]  current_id;
    logic [SLICE_W-1:0] time_slice;
  } out_item_t;

  // queue update command from the sequencer
  typedef struct packed {
    logic push;
    logic pop_adv;
    logic pop_last;
  } q_cmd_t;

endpackage : mps_pkg
`default_nettype wire

// ===== rtl/core/mps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mps_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module mps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule : mps_ram
`default_nettype wire

// ===== rtl/core/mps_apb_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mps_apb_regs
// Apb-style configuration register file holding the base time slice.
// ----------------------------------------------------------------------------
module mps_apb_regs import mps_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [CFG_AW-1:0]  paddr,
  input  wire logic [CFG_DW-1:0]  pwdata,
  output logic      [CFG_DW-1:0]  prdata,
  output logic                    pready,
  output logic      [SBASE_W-1:0] slice_base
);

  logic [SBASE_W-1:0] slice_base_r;
  logic               wr_en;
  logic               sel_base;

  // word index is the upper address bits, byte lanes ignored
  assign sel_base = (paddr[CFG_AW-1 -: 1] == REG_SLICE_BASE);
  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_base_r <= SLICE_BASE_RST;
    end else if (wr_en && sel_base) begin
      slice_base_r <= pwdata[SBASE_W-1:0];
    end
  end

  assign prdata     = sel_base ? CFG_DW'(slice_base_r) : '0;
  assign slice_base = slice_base_r;

endmodule : mps_apb_regs
`default_nettype wire

// ===== rtl/core/mps_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mps_queue
// Head, tail and nonempty flags of the per-priority fifos, with the
// highest-priority select. Links between entries live in the link memory.
// ----------------------------------------------------------------------------
module mps_queue import mps_pkg::*; #(
  parameter int LEVELS = DEF_PRIORITY_LEVELS,
  parameter int TID_W  = $clog2(DEF_MAX_THREADS)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire q_cmd_t                    cmd,
  input  wire logic [$clog2(LEVELS)-1:0] push_lvl,
  input  wire logic [TID_W-1:0]          push_id,
  input  wire logic [$clog2(LEVELS)-1:0] pop_lvl,
  input  wire logic [TID_W-1:0]          pop_next,
  output logic                           push_hit,
  output logic      [TID_W-1:0]          push_tail,
  output logic                           sel_found,
  output logic      [$clog2(LEVELS)-1:0] sel_lvl,
  output logic      [TID_W-1:0]          sel_head,
  output logic                           sel_last,
  output logic      [LEVELS-1:0]         nonempty
);

  localparam int LVL_W = $clog2(LEVELS);

  logic [TID_W-1:0]  head_r [LEVELS];
  logic [TID_W-1:0]  tail_r [LEVELS];
  logic [LEVELS-1:0] nonempty_r;

  assign push_hit  = nonempty_r[push_lvl];
  assign push_tail = tail_r[push_lvl];

  // lowest set bit is the highest priority
  always_comb begin
    sel_found = 1'b0;
    sel_lvl   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty_r[i]) begin
        sel_found = 1'b1;
        sel_lvl   = LVL_W'(i);
      end
    end
  end

  assign sel_head = head_r[sel_lvl];
  assign sel_last = (head_r[sel_lvl] == tail_r[sel_lvl]);
  assign nonempty = nonempty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      if (cmd.push) begin
        if (!nonempty_r[push_lvl]) begin
          head_r[push_lvl] <= push_id;
        end
        tail_r[push_lvl]     <= push_id;
        nonempty_r[push_lvl] <= 1'b1;
      end
      if (cmd.pop_last) begin
        nonempty_r[pop_lvl] <= 1'b0;
      end
      if (cmd.pop_adv) begin
        head_r[pop_lvl] <= pop_next;
      end
    end
  end

endmodule : mps_queue
`default_nettype wire

// ===== rtl/core/multilevel_priority_fifo_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multilevel_priority_fifo_scheduler
// Thread scheduler with one fifo of thread ids per priority level. Thread
// state and priority sit in a thread memory, fifo links in a link memory.
// ----------------------------------------------------------------------------
//   channel   ports                          dir   payload
//   input     in_valid / in_ready / in_data  in    in_item_t
//   result    out_valid / out_ready / out_data out out_item_t
//   config    psel penable pwrite paddr ...  in    slice_base at byte 0
//
// add and start pass exec and out, yield and terminate pass exec, disp,
// disp2 and out, or skip disp2 when every queue is empty: the thread memory
// read-modify-write and the dispatch read of the thread and link memories
// set these steps. after reset a clearing pass writes every thread entry
// unused, during which no item is taken; configuration writes go on.
// a result waiting on out_ready holds the sequencer until its register frees.
// ----------------------------------------------------------------------------
module multilevel_priority_fifo_scheduler import mps_pkg::*; #(
  parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS,
  parameter int MAX_THREADS     = DEF_MAX_THREADS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  localparam int PRI_W  = $clog2(PRIORITY_LEVELS);
  localparam int TID_W  = $clog2(MAX_THREADS);
  localparam int TM_W   = TS_W + PRI_W;
  localparam int MUL_W  = $clog2(PRIORITY_LEVELS + 2);
  localparam int PROD_W = MUL_W + SBASE_W;
  localparam int EXT_W  = PROD_W + SLICE_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_DISP,
    S_DISP2,
    S_OUT
  } state_t;

  state_t             state_r;
  logic [TID_W-1:0]   clr_cnt_r;
  logic [OPCODE_W-1:0] op_r;
  logic [TID_W-1:0]   id_r;
  logic               id_ok_r;
  logic [PRI_W-1:0]   pri_r;
  logic [IST_FW-1:0]  ist_r;
  logic [PRI_W-1:0]   lvl_r;
  logic [TID_W-1:0]   t_r;
  logic               last_r;
  logic [TID_W-1:0]   running_id_r;
  logic               running_valid_r;
  out_item_t          res_r;
  out_item_t          out_data_r;
  logic               out_valid_r;

  logic [SBASE_W-1:0] slice_base;

  // thread memory
  logic               tm_we;
  logic [TID_W-1:0]   tm_waddr;
  logic [TM_W-1:0]    tm_wdata;
  logic [TID_W-1:0]   tm_raddr;
  logic [TM_W-1:0]    tm_rdata;
  tstate_t            tm_state;
  logic [PRI_W-1:0]   tm_pri;

  // link memory
  logic               lm_we;
  logic [TID_W-1:0]   lm_raddr;
  logic [TID_W-1:0]   lm_rdata;

  // queue control
  q_cmd_t             q_cmd;
  logic [PRI_W-1:0]   push_lvl;
  logic [TID_W-1:0]   push_id;
  logic               q_push_hit;
  logic [TID_W-1:0]   q_push_tail;
  logic               q_sel_found;
  logic [PRI_W-1:0]   q_sel_lvl;
  logic [TID_W-1:0]   q_sel_head;
  logic               q_sel_last;
  logic [PRIORITY_LEVELS-1:0] q_nonempty;

  logic               in_acc;
  logic [PRI_W-1:0]   in_pri;
  logic               in_id_ok;
  logic               add_rej;
  logic               start_rej;
  logic               cur_ok;
  tstate_t            add_state;
  logic [TID_FW-1:0]  cur_out;
  logic [MUL_W-1:0]   mult;
  logic [PROD_W-1:0]  prod;
  logic [EXT_W-1:0]   prod_ext;
  logic [SLICE_W-1:0] slice_sat;
  logic               out_free;

  mps_apb_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .slice_base (slice_base)
  );

  mps_ram #(.WIDTH(TM_W), .DEPTH(MAX_THREADS)) u_thread_mem (
    .clk   (clk),
    .we    (tm_we),
    .waddr (tm_waddr),
    .wdata (tm_wdata),
    .raddr (tm_raddr),
    .rdata (tm_rdata)
  );

  mps_ram #(.WIDTH(TID_W), .DEPTH(MAX_THREADS)) u_link_mem (
    .clk   (clk),
    .we    (lm_we),
    .waddr (q_push_tail),
    .wdata (push_id),
    .raddr (lm_raddr),
    .rdata (lm_rdata)
  );

  mps_queue #(.LEVELS(PRIORITY_LEVELS), .TID_W(TID_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .push_lvl  (push_lvl),
    .push_id   (push_id),
    .pop_lvl   (lvl_r),
    .pop_next  (lm_rdata),
    .push_hit  (q_push_hit),
    .push_tail (q_push_tail),
    .sel_found (q_sel_found),
    .sel_lvl   (q_sel_lvl),
    .sel_head  (q_sel_head),
    .sel_last  (q_sel_last),
    .nonempty  (q_nonempty)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // priority saturates to the lowest level
  assign in_pri   = (32'(in_data.priority_level) >= PRIORITY_LEVELS) ?
                    PRI_W'(PRIORITY_LEVELS - 1) : PRI_W'(in_data.priority_level);
  assign in_id_ok = (32'(in_data.thread_id) < MAX_THREADS);

  assign tm_state = tm_rdata[TM_W-1 -: TS_W];
  assign tm_pri   = tm_rdata[PRI_W-1:0];

  assign add_rej   = !id_ok_r || (ist_r == IST_BAD) ||
                     (tm_state == TS_READY) || (tm_state == TS_RUNNING);
  assign start_rej = !id_ok_r || (tm_state != TS_CREATED);
  assign cur_ok    = running_valid_r && (tm_state == TS_RUNNING);
  assign add_state = (ist_r == IST_READY) ? TS_READY :
                     (ist_r == IST_SLEEP) ? TS_SLEEP : TS_CREATED;
  assign cur_out   = running_valid_r ? TID_FW'(running_id_r) : '0;

  // slice = (levels - pri + 1) * base, saturated to the field
  assign mult      = MUL_W'(PRIORITY_LEVELS + 1) - MUL_W'(tm_pri);
  assign prod      = PROD_W'(mult) * PROD_W'(slice_base);
  assign prod_ext  = EXT_W'(prod);
  assign slice_sat = (prod_ext > EXT_W'(SLICE_MAX)) ? SLICE_MAX : prod_ext[SLICE_W-1:0];

  always_comb begin
    tm_we    = 1'b0;
    tm_waddr = id_r;
    tm_wdata = {TS_UNUSED, PRI_W'(0)};
    tm_raddr = q_sel_head;
    lm_raddr = q_sel_head;
    q_cmd    = '0;
    push_lvl = pri_r;
    push_id  = id_r;
    case (state_r)
      S_CLEAR: begin
        tm_we    = 1'b1;
        tm_waddr = clr_cnt_r;
      end
      S_IDLE: begin
        tm_raddr = ((in_data.opcode == OP_ADD) || (in_data.opcode == OP_START)) ?
                   TID_W'(in_data.thread_id) : running_id_r;
      end
      S_EXEC: begin
        case (op_r)
          OP_ADD: begin
            if (!add_rej) begin
              tm_we      = 1'b1;
              tm_wdata   = {add_state, pri_r};
              q_cmd.push = (ist_r == IST_READY);
            end
          end
          OP_START: begin
            push_lvl = tm_pri;
            if (!start_rej) begin
              tm_we      = 1'b1;
              tm_wdata   = {TS_READY, tm_pri};
              q_cmd.push = 1'b1;
            end
          end
          OP_YIELD: begin
            tm_waddr = running_id_r;
            push_lvl = tm_pri;
            push_id  = running_id_r;
            if (cur_ok) begin
              tm_we      = 1'b1;
              tm_wdata   = {TS_READY, tm_pri};
              q_cmd.push = 1'b1;
            end
          end
          default: begin
            tm_waddr = running_id_r;
            if (cur_ok) begin
              tm_we    = 1'b1;
              tm_wdata = {TS_EXITED, tm_pri};
            end
          end
        endcase
      end
      S_DISP2: begin
        tm_we          = 1'b1;
        tm_waddr       = t_r;
        tm_wdata       = {TS_RUNNING, tm_pri};
        q_cmd.pop_last = last_r;
        q_cmd.pop_adv  = !last_r;
      end
      default: begin
      end
    endcase
  end

  // appending behind an existing tail links it to the new item
  assign lm_we = q_cmd.push && q_push_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      clr_cnt_r       <= '0;
      running_id_r    <= '0;
      running_valid_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + TID_W'(1);
          if (clr_cnt_r == TID_W'(MAX_THREADS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_r    <= in_data.opcode;
            id_r    <= TID_W'(in_data.thread_id);
            id_ok_r <= in_id_ok;
            pri_r   <= in_pri;
            ist_r   <= in_data.initial_state;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if ((op_r == OP_ADD) || (op_r == OP_START)) begin
            res_r.status     <= (op_r == OP_ADD) ? add_rej : start_rej;
            res_r.dispatched <= 1'b0;
            res_r.current_id <= cur_out;
            res_r.time_slice <= '0;
            state_r          <= S_OUT;
          end else begin
            running_valid_r <= 1'b0;
            state_r         <= S_DISP;
          end
        end
        S_DISP: begin
          if (q_sel_found) begin
            lvl_r   <= q_sel_lvl;
            t_r     <= q_sel_head;
            last_r  <= q_sel_last;
            state_r <= S_DISP2;
          end else begin
            res_r   <= '0;
            state_r <= S_OUT;
          end
        end
        S_DISP2: begin
          running_id_r     <= t_r;
          running_valid_r  <= 1'b1;
          res_r.status     <= 1'b0;
          res_r.dispatched <= 1'b1;
          res_r.current_id <= TID_FW'(t_r);
          res_r.time_slice <= slice_sat;
          state_r          <= S_OUT;
        end
        S_OUT: begin
          // a free register takes the item, a held one keeps its valid
          if (out_free) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a pop only takes from a level that holds items
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISP2) |-> q_nonempty[lvl_r])
    else $error("pop from empty priority level");

  // push and pop never share a cycle
  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_cmd.push && (q_cmd.pop_adv || q_cmd.pop_last)))
    else $error("queue push and pop in the same cycle");

  // a free result register takes the pending item
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OUT) && out_free) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("result not loaded");

  // a rejected item never dispatches
  a_rej_no_disp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.status && out_data_r.dispatched))
    else $error("rejected item reports a dispatch");

  // a dispatch always leaves a current thread
  a_disp_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISP2) |=> running_valid_r)
    else $error("dispatch without a current thread");

endmodule : multilevel_priority_fifo_scheduler
`default_nettype wire

// ===== tb/tb_multilevel_priority_fifo_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multilevel_priority_fifo_scheduler
// Drives scheduler operations through the input channel and checks every
// result against a predictor that tracks thread states, per-level fifos and
// the current thread, across several slice_base settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_multilevel_priority_fifo_scheduler;
  import mps_pkg::*;

  localparam int LEVELS        = DEF_PRIORITY_LEVELS;
  localparam int NTHREADS      = DEF_MAX_THREADS;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 200;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  // scheduler state as predicted
  tstate_t             thr_state [NTHREADS];
  logic [PRI_FW-1:0]   thr_pri [NTHREADS];
  int unsigned         link_next [NTHREADS];
  int unsigned         q_head [LEVELS];
  int unsigned         q_tail [LEVELS];
  logic [LEVELS-1:0]   q_busy = '0;
  int unsigned         run_id = 0;
  logic                run_valid = 1'b0;
  logic [SBASE_W-1:0]  slice_base = SLICE_BASE_RST;

  in_item_t            pending_ops [$];
  out_item_t           expected_results [$];
  int unsigned         in_gap = 0;
  int unsigned         out_stall = 0;
  logic                no_idle = 1'b0;
  int unsigned         fail_count = 0;
  int unsigned         cycle_count = 0;

  multilevel_priority_fifo_scheduler #(
    .PRIORITY_LEVELS(LEVELS),
    .MAX_THREADS    (NTHREADS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic int unsigned idle_draw();
    if (no_idle) return 0;
    return $urandom_range(0, 10);
  endfunction

  function automatic void level_push(int unsigned lvl, int unsigned tid);
    if (q_busy[lvl]) link_next[q_tail[lvl]] = tid;
    else q_head[lvl] = tid;
    q_tail[lvl] = tid;
    q_busy[lvl] = 1'b1;
  endfunction

  function automatic out_item_t predict_schedule(in_item_t it);
    out_item_t   res;
    int unsigned pri, tid, lvl, t, span;
    logic        found;
    res = '0;
    pri = it.priority_level;
    if (pri >= LEVELS) pri = LEVELS - 1;
    tid = it.thread_id;
    case (it.opcode)
      OP_ADD: begin
        if (tid >= NTHREADS || it.initial_state == IST_BAD ||
            thr_state[tid] == TS_READY || thr_state[tid] == TS_RUNNING) begin
          res.status = 1'b1;
        end else begin
          thr_pri[tid] = PRI_FW'(pri);
          if (it.initial_state == IST_READY) begin
            thr_state[tid] = TS_READY;
            level_push(pri, tid);
          end else if (it.initial_state == IST_SLEEP) begin
            thr_state[tid] = TS_SLEEP;
          end else begin
            thr_state[tid] = TS_CREATED;
          end
        end
      end
      OP_START: begin
        if (tid >= NTHREADS || thr_state[tid] != TS_CREATED) begin
          res.status = 1'b1;
        end else begin
          thr_state[tid] = TS_READY;
          level_push(thr_pri[tid], tid);
        end
      end
      default: begin
        // yield and terminate act on the current thread, then dispatch
        if (run_valid && run_id < NTHREADS && thr_state[run_id] == TS_RUNNING) begin
          if (it.opcode == OP_YIELD) begin
            thr_state[run_id] = TS_READY;
            level_push(thr_pri[run_id], run_id);
          end else begin
            thr_state[run_id] = TS_EXITED;
          end
        end
        run_valid = 1'b0;
        found = 1'b0;
        for (lvl = 0; lvl < LEVELS; lvl++) begin
          if (!found && q_busy[lvl]) begin
            t = q_head[lvl];
            if (t == q_tail[lvl]) q_busy[lvl] = 1'b0;
            else q_head[lvl] = link_next[t];
            thr_state[t] = TS_RUNNING;
            run_id = t;
            run_valid = 1'b1;
            found = 1'b1;
            span = (LEVELS - thr_pri[t] + 1) * slice_base;
            res.dispatched = 1'b1;
            res.time_slice = (span > SLICE_MAX) ? SLICE_MAX : SLICE_W'(span);
          end
        end
      end
    endcase
    res.current_id = run_valid ? TID_FW'(run_id) : '0;
    return res;
  endfunction

  // sender: one item per handshake, random gap after each
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(predict_schedule(in_data));
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (pending_ops.size() != 0) begin
          in_data  <= pending_ops.pop_front();
          in_valid <= 1'b1;
          in_gap   <= idle_draw();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result, stalls a random count after it
  always @(posedge clk) begin
    out_item_t   want;
    int unsigned hold;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      hold = (out_stall != 0) ? out_stall - 1 : 0;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result: status %0d dispatched %0d id %0d slice %0d",
                                 out_data.status, out_data.dispatched, out_data.current_id,
                                 out_data.time_slice));
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status || out_data.dispatched !== want.dispatched ||
              out_data.current_id !== want.current_id ||
              out_data.time_slice !== want.time_slice) begin
            note_failure($sformatf({"result mismatch: expected status %0d dispatched %0d ",
                                    "id %0d slice %0d, got status %0d dispatched %0d ",
                                    "id %0d slice %0d"},
                                   want.status, want.dispatched, want.current_id,
                                   want.time_slice, out_data.status, out_data.dispatched,
                                   out_data.current_id, out_data.time_slice));
          end
        end
        hold = idle_draw();
      end
      out_stall <= hold;
      out_ready <= (hold == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_op(input int unsigned op, input int unsigned tid,
                          input int unsigned pri, input int unsigned ist);
    in_item_t it;
    it.opcode         = OPCODE_W'(op);
    it.thread_id      = TID_FW'(tid);
    it.priority_level = PRI_FW'(pri);
    it.initial_state  = IST_FW'(ist);
    pending_ops.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    slice_base = data[SBASE_W-1:0];
    // psel stays high: this cycle is the read setup
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[SBASE_W-1:0] !== data[SBASE_W-1:0])
      note_failure($sformatf("slice_base read back %0d, wrote %0d",
                             prdata[SBASE_W-1:0], data[SBASE_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // mostly well-formed traffic over a small id pool so threads collide
  task automatic queue_random(input int unsigned count);
    int unsigned n, sel, tid;
    n = 0;
    while (n < count) begin
      sel = $urandom_range(0, 99);
      tid = ($urandom_range(0, 9) < 3) ? $urandom_range(0, NTHREADS - 1) : $urandom_range(0, 15);
      if (sel < 30) begin
        queue_op(OP_ADD, tid, $urandom_range(0, 7), IST_READY);
        n += 1;
      end else if (sel < 45) begin
        queue_op(OP_ADD, tid, $urandom_range(0, 7), IST_CREATED);
        if ($urandom_range(0, 1)) queue_op(OP_YIELD, 0, $urandom_range(0, 7), IST_READY);
        queue_op(OP_START, tid, $urandom_range(0, 7), $urandom_range(0, 3));
        n += 2;
      end else if (sel < 65) begin
        queue_op(OP_YIELD, $urandom_range(0, 63), $urandom_range(0, 7), $urandom_range(0, 3));
        n += 1;
      end else if (sel < 82) begin
        queue_op(OP_TERM, $urandom_range(0, 63), $urandom_range(0, 7), $urandom_range(0, 3));
        n += 1;
      end else if (sel < 88) begin
        queue_op(OP_ADD, tid, $urandom_range(0, 7), IST_SLEEP);
        n += 1;
      end else begin
        queue_op($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 7),
                 $urandom_range(0, 3));
        n += 1;
      end
    end
  endtask

  initial begin
    int unsigned slice_plan [6];
    int unsigned val;
    slice_plan = '{1, 65535, 0, 2, 0, 10};
    foreach (thr_state[i]) begin
      thr_state[i] = TS_UNUSED;
      thr_pri[i]   = '0;
      link_next[i] = 0;
    end
    foreach (q_head[i]) begin
      q_head[i] = 0;
      q_tail[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset slice_base
    queue_op(OP_YIELD, 0, 0, IST_READY);      // nothing to run
    queue_op(OP_TERM, 63, 7, IST_BAD);
    queue_op(OP_START, 5, 0, IST_READY);      // never added
    queue_op(OP_ADD, 0, 0, IST_READY);
    queue_op(OP_ADD, 63, 7, IST_READY);
    queue_op(OP_ADD, 63, 2, IST_READY);       // already queued
    queue_op(OP_ADD, 10, 1, IST_BAD);
    queue_op(OP_ADD, 20, 3, IST_SLEEP);
    queue_op(OP_ADD, 21, 5, IST_CREATED);
    queue_op(OP_START, 21, 7, IST_READY);
    queue_op(OP_START, 21, 0, IST_READY);     // already ready
    queue_op(OP_START, 20, 0, IST_READY);     // sleeping
    queue_op(OP_ADD, 20, 3, IST_READY);       // sleeping record overwritten
    queue_op(OP_YIELD, 0, 0, IST_READY);
    queue_op(OP_YIELD, 0, 0, IST_READY);      // only thread at top level comes back
    queue_op(OP_ADD, 0, 4, IST_READY);        // running
    queue_op(OP_TERM, 0, 0, IST_READY);
    queue_op(OP_ADD, 0, 7, IST_CREATED);      // exited record overwritten
    queue_op(OP_START, 0, 0, IST_SLEEP);
    queue_op(OP_YIELD, 0, 0, IST_READY);
    repeat (5) queue_op(OP_TERM, 0, 0, IST_READY);
    queue_op(OP_YIELD, 0, 0, IST_READY);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      val = (slice_plan[p] != 0) ? slice_plan[p] : $urandom_range(3, 65534);
      cfg_write(CFG_AW'(4 * REG_SLICE_BASE), CFG_DW'(val));
      no_idle = (p == 2 || p == 4);
      queue_random(PHASE_ITEMS);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
